@@ design/obm_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared constants: parameter defaults, opcodes, result kinds and bus widths.
// ----------------------------------------------------------------------------
package obm_pkg;

    // Default sizes of the book.
    localparam int DEF_PRICE_LEVELS = 256;
    localparam int DEF_ORDER_SLOTS  = 32;
    localparam int DEF_ID_BITS      = 32;

    // Input opcodes; both remaining codes mean cancel.
    localparam logic [1:0] OP_LIMIT  = 2'd0;
    localparam logic [1:0] OP_MARKET = 2'd1;

    // Result kinds.
    localparam logic [2:0] K_TRADE     = 3'd0;
    localparam logic [2:0] K_RESTED    = 3'd1;
    localparam logic [2:0] K_FILLED    = 3'd2;
    localparam logic [2:0] K_EXPIRED   = 3'd3;
    localparam logic [2:0] K_CANCELLED = 3'd4;
    localparam logic [2:0] K_NOT_FOUND = 3'd5;
    localparam logic [2:0] K_FULL      = 3'd6;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 176;
    localparam int M_TUSER_W = 3;

endpackage

@@ design/limit_order_book_matcher.sv @@
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching engine over a per-side price ladder.
// ----------------------------------------------------------------------------
// Usage: one order transaction enters on the s_ channel (limit, market or
// cancel). The m_ channel returns one trade transaction per fill, followed by
// one status transaction with tlast high that carries the best bid and ask.
// Orders are handled one at a time. A trade checks the best level, reads the
// level, then reads the resting order; when the resting order is used up it is
// also unlinked from its level. When a best level empties, the next best is
// found by reading the occupancy flags one tick per cycle. A cancel walks the
// used slots in index order to look up its id, then unlinks the order. Resting
// a remainder reads the level, writes the level and the new slot, and links the
// new slot behind the old tail of an occupied level. Level heads, tails and
// occupancy live in one RAM, the order slots in another; both have a registered
// read port. After reset a clearing pass over every entry empties the level RAM
// while s_tready stays low. A result waits in the output register while the
// receiver stalls; the engine holds until that register frees, and s_tready is
// high only between orders.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import obm_pkg::*;
#(
    parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
    parameter int ORDER_SLOTS  = DEF_ORDER_SLOTS,
    parameter int ID_BITS      = DEF_ID_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ident[31:0], price[39:32], quantity[71:40], timestamp[119:72]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[1:0], side[2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // buyer_id[31:0], seller_id[63:32], trade_price[71:64],
    // trade_quantity[103:72], trade_time[151:104], resting_filled[152],
    // bid_present[153], bid_tick[161:154], ask_present[162], ask_tick[170:163]
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [M_TUSER_W-1:0] m_tuser,
    // last
    output logic                 m_tlast
);

    localparam int TW    = (PRICE_LEVELS > 2) ? $clog2(PRICE_LEVELS) : 1;
    localparam int LW    = TW + 1;
    localparam int LDEP  = 2 ** LW;
    localparam int SW    = (ORDER_SLOTS > 2) ? $clog2(ORDER_SLOTS) : 1;
    localparam int IDW   = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int SLW   = IDW + 32 + TW + 1 + 2 * SW;

    typedef struct packed {
        logic [IDW-1:0] id;
        logic [31:0]    rem;
        logic [TW-1:0]  price;
        logic           side;
        logic [SW-1:0]  nxt;
        logic [SW-1:0]  prv;
    } slot_t;

    typedef struct packed {
        logic          occ;
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
    } level_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_C_ADDR, ST_C_CMP, ST_SW_CHK, ST_SW_LV, ST_SW_SL,
        ST_U_RD, ST_U_LV, ST_U_P, ST_U_N, ST_RS_ADDR, ST_RS_CHK, ST_END,
        ST_A_LV, ST_A_T, ST_STATUS, ST_CLEAR
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   clr_reg, clr_next;
    logic [1:0]      op_reg, op_next;
    logic            sd_reg, sd_next;
    logic [IDW-1:0]  id_reg, id_next;
    logic [TW-1:0]   price_reg, price_next;
    logic [31:0]     rem_reg, rem_next;
    logic [47:0]     ts_reg, ts_next;
    logic [2:0]      kind_reg, kind_next;
    slot_t           cur_reg, cur_next;
    logic [SW-1:0]   cur_idx_reg, cur_idx_next;
    level_t          lvl_reg, lvl_next;
    logic [SW:0]     scan_reg, scan_next;
    logic            from_sweep_reg, from_sweep_next;
    logic            rs_side_reg, rs_side_next;
    logic [TW-1:0]   rs_idx_reg, rs_idx_next;
    logic [SW-1:0]   free_idx_reg, free_idx_next;
    logic [ORDER_SLOTS-1:0] used_reg, used_next;
    logic            bid_pres_reg, bid_pres_next;
    logic [TW-1:0]   bid_reg, bid_next;
    logic            ask_pres_reg, ask_pres_next;
    logic [TW-1:0]   ask_reg, ask_next;

    // Output register.
    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_kind_reg, m_kind_next;
    logic [31:0]     m_buy_reg, m_buy_next;
    logic [31:0]     m_sell_reg, m_sell_next;
    logic [7:0]      m_price_reg, m_price_next;
    logic [31:0]     m_qty_reg, m_qty_next;
    logic [47:0]     m_time_reg, m_time_next;
    logic            m_rf_reg, m_rf_next;
    logic            m_bp_reg, m_bp_next;
    logic [7:0]      m_bb_reg, m_bb_next;
    logic            m_ap_reg, m_ap_next;
    logic [7:0]      m_ba_reg, m_ba_next;
    logic            m_last_reg, m_last_next;

    // RAM ports.
    logic            s_we;
    logic [SW-1:0]   s_waddr, s_raddr;
    slot_t           s_wdata, s_rd;
    logic [SLW-1:0]  s_rd_raw;
    logic            l_we;
    logic [LW-1:0]   l_waddr, l_raddr;
    level_t          l_wdata, l_rd;
    logic [2*SW:0]   l_rd_raw;

    obm_ram #(.WIDTH(SLW), .DEPTH(2 ** SW)) u_slot_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rd_raw)
    );

    obm_ram #(.WIDTH(2 * SW + 1), .DEPTH(LDEP)) u_level_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rd_raw)
    );

    assign s_rd = slot_t'(s_rd_raw);
    assign l_rd = level_t'(l_rd_raw);

    // Lowest free order slot.
    logic          free_any;
    logic [SW-1:0] free_idx;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // Helpers for the sweep, the unlink and the rescan.
    logic          out_free;
    logic          opp_pres;
    logic [TW-1:0] opp_best;
    logic [31:0]   fill_q;
    logic [31:0]   slot_left;
    logic          is_head, is_tail;
    logic [TW-1:0] rs_step;
    state_t        ret_state;
    slot_t         w_slot;

    assign out_free  = !m_valid_reg || m_tready;
    assign opp_pres  = sd_reg ? bid_pres_reg : ask_pres_reg;
    assign opp_best  = sd_reg ? bid_reg : ask_reg;
    assign fill_q    = (rem_reg < s_rd.rem) ? rem_reg : s_rd.rem;
    assign slot_left = s_rd.rem - fill_q;
    assign is_head   = l_rd.head == cur_idx_reg;
    assign is_tail   = l_rd.tail == cur_idx_reg;
    assign rs_step   = rs_side_reg ? (rs_idx_reg + 1'b1) : (rs_idx_reg - 1'b1);
    assign ret_state = from_sweep_reg ? ST_SW_CHK : ST_STATUS;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        sd_next         = sd_reg;
        id_next         = id_reg;
        price_next      = price_reg;
        rem_next        = rem_reg;
        ts_next         = ts_reg;
        kind_next       = kind_reg;
        cur_next        = cur_reg;
        cur_idx_next    = cur_idx_reg;
        lvl_next        = lvl_reg;
        scan_next       = scan_reg;
        from_sweep_next = from_sweep_reg;
        rs_side_next    = rs_side_reg;
        rs_idx_next     = rs_idx_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        bid_pres_next   = bid_pres_reg;
        bid_next        = bid_reg;
        ask_pres_next   = ask_pres_reg;
        ask_next        = ask_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_buy_next   = m_buy_reg;
        m_sell_next  = m_sell_reg;
        m_price_next = m_price_reg;
        m_qty_next   = m_qty_reg;
        m_time_next  = m_time_reg;
        m_rf_next    = m_rf_reg;
        m_bp_next    = m_bp_reg;
        m_bb_next    = m_bb_reg;
        m_ap_next    = m_ap_reg;
        m_ba_next    = m_ba_reg;
        m_last_next  = m_last_reg;

        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_raddr = '0;
        w_slot  = '0;

        case (state_reg)
            // Mark every level empty, one entry per cycle after reset.
            ST_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = clr_reg;
                l_wdata = '0;
                if (clr_reg == LW'(LDEP - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[1:0];
                    sd_next    = s_tuser[2];
                    id_next    = IDW'(s_tdata[31:0]);
                    if (32'(s_tdata[39:32]) >= 32'(PRICE_LEVELS)) begin
                        price_next = TW'(PRICE_LEVELS - 1);
                    end else begin
                        price_next = TW'(s_tdata[39:32]);
                    end
                    rem_next   = s_tdata[71:40];
                    ts_next    = s_tdata[119:72];
                    scan_next  = '0;
                    if (s_tuser[1]) begin
                        state_next = ST_C_ADDR;
                    end else begin
                        state_next = ST_SW_CHK;
                    end
                end
            end

            // Cancel: walk the used slots in index order.
            ST_C_ADDR: begin
                if (scan_reg == (SW + 1)'(ORDER_SLOTS)) begin
                    kind_next  = K_NOT_FOUND;
                    rem_next   = '0;
                    state_next = ST_STATUS;
                end else if (used_reg[scan_reg[SW-1:0]]) begin
                    s_raddr    = scan_reg[SW-1:0];
                    state_next = ST_C_CMP;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_C_CMP: begin
                if (s_rd.id == id_reg) begin
                    cur_next        = s_rd;
                    cur_idx_next    = scan_reg[SW-1:0];
                    rem_next        = s_rd.rem;
                    kind_next       = K_CANCELLED;
                    from_sweep_next = 1'b0;
                    state_next      = ST_U_RD;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_C_ADDR;
                end
            end

            // Sweep: decide whether the best opposite level still crosses.
            ST_SW_CHK: begin
                if (rem_reg == '0 || !opp_pres) begin
                    state_next = ST_END;
                end else if (op_reg == OP_LIMIT &&
                             (sd_reg ? (opp_best < price_reg)
                                     : (opp_best > price_reg))) begin
                    state_next = ST_END;
                end else begin
                    l_raddr    = {~sd_reg, opp_best};
                    state_next = ST_SW_LV;
                end
            end

            ST_SW_LV: begin
                lvl_next     = l_rd;
                s_raddr      = l_rd.head;
                cur_idx_next = l_rd.head;
                state_next   = ST_SW_SL;
            end

            // Fill against the head order of the level; keep reading it while
            // the output register is busy.
            ST_SW_SL: begin
                s_raddr = cur_idx_reg;
                if (out_free) begin
                    rem_next     = rem_reg - fill_q;
                    m_valid_next = 1'b1;
                    m_kind_next  = K_TRADE;
                    m_buy_next   = sd_reg ? 32'(s_rd.id) : 32'(id_reg);
                    m_sell_next  = sd_reg ? 32'(id_reg) : 32'(s_rd.id);
                    m_price_next = 8'(opp_best);
                    m_qty_next   = fill_q;
                    m_time_next  = ts_reg;
                    m_rf_next    = slot_left == '0;
                    m_bp_next    = 1'b0;
                    m_bb_next    = '0;
                    m_ap_next    = 1'b0;
                    m_ba_next    = '0;
                    m_last_next  = 1'b0;
                    w_slot       = s_rd;
                    w_slot.rem   = slot_left;
                    cur_next     = w_slot;
                    if (slot_left != '0) begin
                        s_we       = 1'b1;
                        s_waddr    = cur_idx_reg;
                        s_wdata    = w_slot;
                        state_next = ST_SW_CHK;
                    end else begin
                        from_sweep_next = 1'b1;
                        state_next      = ST_U_RD;
                    end
                end
            end

            // Unlink the current slot from its level.
            ST_U_RD: begin
                l_raddr    = {cur_reg.side, cur_reg.price};
                state_next = ST_U_LV;
            end

            ST_U_LV: begin
                used_next[cur_idx_reg] = 1'b0;
                lvl_next = l_rd;
                if (is_head && is_tail) begin
                    l_we    = 1'b1;
                    l_waddr = {cur_reg.side, cur_reg.price};
                    l_wdata = '{occ: 1'b0, head: l_rd.head, tail: l_rd.tail};
                    if (cur_reg.side ? (ask_pres_reg && ask_reg == cur_reg.price)
                                     : (bid_pres_reg && bid_reg == cur_reg.price)) begin
                        rs_side_next = cur_reg.side;
                        rs_idx_next  = cur_reg.price;
                        state_next   = ST_RS_ADDR;
                    end else begin
                        state_next = ret_state;
                    end
                end else if (is_head) begin
                    l_we       = 1'b1;
                    l_waddr    = {cur_reg.side, cur_reg.price};
                    l_wdata    = '{occ: 1'b1, head: cur_reg.nxt, tail: l_rd.tail};
                    state_next = ret_state;
                end else if (is_tail) begin
                    l_we       = 1'b1;
                    l_waddr    = {cur_reg.side, cur_reg.price};
                    l_wdata    = '{occ: 1'b1, head: l_rd.head, tail: cur_reg.prv};
                    state_next = ret_state;
                end else begin
                    s_raddr    = cur_reg.prv;
                    state_next = ST_U_P;
                end
            end

            ST_U_P: begin
                w_slot     = s_rd;
                w_slot.nxt = cur_reg.nxt;
                s_we       = 1'b1;
                s_waddr    = cur_reg.prv;
                s_wdata    = w_slot;
                s_raddr    = cur_reg.nxt;
                state_next = ST_U_N;
            end

            ST_U_N: begin
                w_slot     = s_rd;
                w_slot.prv = cur_reg.prv;
                s_we       = 1'b1;
                s_waddr    = cur_reg.nxt;
                s_wdata    = w_slot;
                state_next = ret_state;
            end

            // Step away from an emptied best level until an occupied tick, or mark the side empty at the last tick.
            ST_RS_ADDR: begin
                l_raddr    = {rs_side_reg, rs_idx_reg};
                state_next = ST_RS_CHK;
            end

            ST_RS_CHK: begin
                if (l_rd.occ) begin
                    if (rs_side_reg) begin
                        ask_next = rs_idx_reg;
                    end else begin
                        bid_next = rs_idx_reg;
                    end
                    state_next = ret_state;
                end else if (rs_side_reg ? (rs_idx_reg == TW'(PRICE_LEVELS - 1))
                                         : (rs_idx_reg == '0)) begin
                    if (rs_side_reg) begin
                        ask_pres_next = 1'b0;
                    end else begin
                        bid_pres_next = 1'b0;
                    end
                    state_next = ret_state;
                end else begin
                    rs_idx_next = rs_step;
                    l_raddr     = {rs_side_reg, rs_step};
                end
            end

            // Settle the remainder: filled, expired, rejected or rested.
            ST_END: begin
                if (rem_reg == '0) begin
                    kind_next  = K_FILLED;
                    state_next = ST_STATUS;
                end else if (op_reg == OP_MARKET) begin
                    kind_next  = K_EXPIRED;
                    state_next = ST_STATUS;
                end else if (!free_any) begin
                    kind_next  = K_FULL;
                    state_next = ST_STATUS;
                end else begin
                    kind_next           = K_RESTED;
                    free_idx_next       = free_idx;
                    used_next[free_idx] = 1'b1;
                    w_slot = '{id: id_reg, rem: rem_reg, price: price_reg,
                               side: sd_reg, nxt: '0, prv: '0};
                    cur_next = w_slot;
                    if (sd_reg) begin
                        if (!ask_pres_reg || price_reg < ask_reg) begin
                            ask_pres_next = 1'b1;
                            ask_next      = price_reg;
                        end
                    end else begin
                        if (!bid_pres_reg || price_reg > bid_reg) begin
                            bid_pres_next = 1'b1;
                            bid_next      = price_reg;
                        end
                    end
                    l_raddr    = {sd_reg, price_reg};
                    state_next = ST_A_LV;
                end
            end

            // Start a new level, or append behind the tail of an occupied one.
            ST_A_LV: begin
                lvl_next = l_rd;
                l_we     = 1'b1;
                l_waddr  = {sd_reg, price_reg};
                s_we     = 1'b1;
                s_waddr  = free_idx_reg;
                if (l_rd.occ) begin
                    l_wdata    = '{occ: 1'b1, head: l_rd.head, tail: free_idx_reg};
                    w_slot     = cur_reg;
                    w_slot.prv = l_rd.tail;
                    s_wdata    = w_slot;
                    s_raddr    = l_rd.tail;
                    state_next = ST_A_T;
                end else begin
                    l_wdata    = '{occ: 1'b1, head: free_idx_reg, tail: free_idx_reg};
                    s_wdata    = cur_reg;
                    state_next = ST_STATUS;
                end
            end

            ST_A_T: begin
                w_slot     = s_rd;
                w_slot.nxt = free_idx_reg;
                s_we       = 1'b1;
                s_waddr    = lvl_reg.tail;
                s_wdata    = w_slot;
                state_next = ST_STATUS;
            end

            // Closing status transaction with the best prices.
            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_buy_next   = 32'(id_reg);
                    m_sell_next  = '0;
                    m_price_next = '0;
                    m_qty_next   = rem_reg;
                    m_time_next  = ts_reg;
                    m_rf_next    = 1'b0;
                    m_bp_next    = bid_pres_reg;
                    m_bb_next    = bid_pres_reg ? 8'(bid_reg) : 8'd0;
                    m_ap_next    = ask_pres_reg;
                    m_ba_next    = ask_pres_reg ? 8'(ask_reg) : 8'd0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, book bits and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            used_reg     <= '0;
            bid_pres_reg <= 1'b0;
            ask_pres_reg <= 1'b0;
            bid_reg      <= '0;
            ask_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            used_reg     <= used_next;
            bid_pres_reg <= bid_pres_next;
            ask_pres_reg <= ask_pres_next;
            bid_reg      <= bid_next;
            ask_reg      <= ask_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg         <= op_next;
        sd_reg         <= sd_next;
        id_reg         <= id_next;
        price_reg      <= price_next;
        rem_reg        <= rem_next;
        ts_reg         <= ts_next;
        kind_reg       <= kind_next;
        cur_reg        <= cur_next;
        cur_idx_reg    <= cur_idx_next;
        lvl_reg        <= lvl_next;
        scan_reg       <= scan_next;
        from_sweep_reg <= from_sweep_next;
        rs_side_reg    <= rs_side_next;
        rs_idx_reg     <= rs_idx_next;
        free_idx_reg   <= free_idx_next;
        m_kind_reg     <= m_kind_next;
        m_buy_reg      <= m_buy_next;
        m_sell_reg     <= m_sell_next;
        m_price_reg    <= m_price_next;
        m_qty_reg      <= m_qty_next;
        m_time_reg     <= m_time_next;
        m_rf_reg       <= m_rf_next;
        m_bp_reg       <= m_bp_next;
        m_bb_reg       <= m_bb_next;
        m_ap_reg       <= m_ap_next;
        m_ba_reg       <= m_ba_next;
        m_last_reg     <= m_last_next;
    end

    // Ports.
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_ba_reg, m_ap_reg, m_bb_reg, m_bp_reg, m_rf_reg,
                       m_time_reg, m_qty_reg, m_price_reg, m_sell_reg, m_buy_reg};

    // Between orders the book is never crossed.
    a_not_crossed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && bid_pres_reg && ask_pres_reg) |-> bid_reg < ask_reg)
        else $error("best bid at or above best ask");

    // A stalled result stays on the bus unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready)
            |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // An empty slot pool means an empty book.
    a_empty_book: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $countones(used_reg) == 0)
            |-> (!bid_pres_reg && !ask_pres_reg))
        else $error("best price present with no resting order");

endmodule

@@ design/obm_ram.sv @@
// ----------------------------------------------------------------------------
// Order book matcher RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module obm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/limit_order_book_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// Limit order book matcher testbench
// Drives order transactions into the matcher, predicts every trade and status
// transaction with a price-time priority book of its own, and compares each
// result field by field under random idling, stalls and a long receiver hold.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;
    import obm_pkg::*;

    localparam int LEVELS    = 256;
    localparam int SLOTS     = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        side;
        logic [31:0] ident;
        logic [7:0]  price;
        logic [31:0] quantity;
        logic [47:0] timestamp;
    } order_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [7:0]  px;
        logic [31:0] qty;
        logic [47:0] ts;
        logic        rest_done;
        logic        bid_ok;
        logic [7:0]  bid;
        logic        ask_ok;
        logic [7:0]  ask;
        logic        tlast;
    } fill_t;

    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Book model and store of expected fills and status transactions.
    class book_scoreboard;
        logic [4:0]  lvl_head [2*LEVELS];
        logic [4:0]  lvl_tail [2*LEVELS];
        bit          lvl_busy [2*LEVELS];
        bit          slot_busy [SLOTS];
        logic [31:0] slot_id  [SLOTS];
        logic [31:0] slot_left[SLOTS];
        logic [7:0]  slot_px  [SLOTS];
        logic        slot_sd  [SLOTS];
        logic [4:0]  slot_nxt [SLOTS];
        logic [4:0]  slot_prv [SLOTS];
        fill_t       expected_fills[$];
        int          mismatches;
        int          results_seen;
        int          trades_seen;
        int          kinds_seen[8];

        function new();
            foreach (lvl_busy[i]) lvl_busy[i] = 0;
            foreach (slot_busy[i]) slot_busy[i] = 0;
            mismatches = 0;
            results_seen = 0;
            trades_seen = 0;
            foreach (kinds_seen[i]) kinds_seen[i] = 0;
        endfunction

        function bit best_tick(bit sd, output logic [7:0] t);
            int p;
            for (int i = 0; i < LEVELS; i++) begin
                p = sd ? i : LEVELS - 1 - i;
                if (lvl_busy[sd*LEVELS + p]) begin
                    t = p[7:0];
                    return 1;
                end
            end
            t = 0;
            return 0;
        endfunction

        function void unlink(int lv, logic [4:0] s);
            bit hd;
            bit tl;
            hd = lvl_head[lv] == s;
            tl = lvl_tail[lv] == s;
            if (hd && tl) lvl_busy[lv] = 0;
            else if (hd) lvl_head[lv] = slot_nxt[s];
            else if (tl) lvl_tail[lv] = slot_prv[s];
            else begin
                slot_nxt[slot_prv[s]] = slot_nxt[s];
                slot_prv[slot_nxt[s]] = slot_prv[s];
            end
            slot_busy[s] = 0;
        endfunction

        // Works out every result that one accepted order transaction causes.
        function void note_order(order_t o);
            fill_t f;
            logic [31:0] left;
            logic [31:0] q;
            logic [7:0]  t;
            logic [2:0]  status;
            logic [31:0] status_qty;
            int hit;
            int lv;
            logic [4:0] s;
            bit opp;
            left = o.quantity;
            status_qty = 0;
            if (o.opcode == OP_CANCEL || o.opcode == OP_SPARE) begin
                hit = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_busy[i] && slot_id[i] == o.ident) hit = i;
                if (hit < 0) begin
                    status = K_NOT_FOUND;
                end else begin
                    status_qty = slot_left[hit];
                    unlink(slot_sd[hit]*LEVELS + slot_px[hit], hit[4:0]);
                    status = K_CANCELLED;
                end
            end else begin
                opp = ~o.side;
                while (left > 0 && best_tick(opp, t)) begin
                    if (o.opcode == OP_LIMIT && (o.side == 0 ? t > o.price : t < o.price))
                        break;
                    lv = opp*LEVELS + t;
                    s = lvl_head[lv];
                    q = left < slot_left[s] ? left : slot_left[s];
                    left -= q;
                    slot_left[s] -= q;
                    f = '0;
                    f.kind = K_TRADE;
                    f.buy_id = o.side ? slot_id[s] : o.ident;
                    f.sell_id = o.side ? o.ident : slot_id[s];
                    f.px = t;
                    f.qty = q;
                    f.ts = o.timestamp;
                    f.rest_done = slot_left[s] == 0;
                    expected_fills = {expected_fills, f};
                    if (f.rest_done) unlink(lv, s);
                end
                status_qty = left;
                if (left == 0) status = K_FILLED;
                else if (o.opcode == OP_MARKET) status = K_EXPIRED;
                else begin
                    hit = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && !slot_busy[i]) hit = i;
                    if (hit < 0) status = K_FULL;
                    else begin
                        slot_busy[hit] = 1;
                        slot_id[hit] = o.ident;
                        slot_left[hit] = left;
                        slot_px[hit] = o.price;
                        slot_sd[hit] = o.side;
                        lv = o.side*LEVELS + o.price;
                        if (!lvl_busy[lv]) begin
                            lvl_head[lv] = hit[4:0];
                            lvl_tail[lv] = hit[4:0];
                            lvl_busy[lv] = 1;
                        end else begin
                            slot_nxt[lvl_tail[lv]] = hit[4:0];
                            slot_prv[hit] = lvl_tail[lv];
                            lvl_tail[lv] = hit[4:0];
                        end
                        status = K_RESTED;
                    end
                end
            end
            f = '0;
            f.kind = status;
            f.buy_id = o.ident;
            f.qty = status_qty;
            f.ts = o.timestamp;
            f.bid_ok = best_tick(0, f.bid);
            f.ask_ok = best_tick(1, f.ask);
            f.tlast = 1;
            expected_fills = {expected_fills, f};
        endfunction

        // Compares one accepted result transaction with the oldest expectation.
        function void check_result(logic [M_TDATA_W-1:0] data, logic [2:0] kind, logic lst);
            fill_t got;
            fill_t exp_f;
            got.kind = kind;
            got.buy_id = data[31:0];
            got.sell_id = data[63:32];
            got.px = data[71:64];
            got.qty = data[103:72];
            got.ts = data[151:104];
            got.rest_done = data[152];
            got.bid_ok = data[153];
            got.bid = data[161:154];
            got.ask_ok = data[162];
            got.ask = data[170:163];
            got.tlast = lst;
            results_seen++;
            if (expected_fills.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
                return;
            end
            exp_f = expected_fills[0];
            expected_fills.delete(0);
            if (kind <= K_FULL) kinds_seen[kind]++;
            if (kind == K_TRADE) trades_seen++;
            if (got !== exp_f || data[M_TDATA_W-1:171] !== '0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch at %0t", $time);
                    $display("  expected %p", exp_f);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    book_scoreboard book;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          idle_count;
    int          orders_sent;
    logic [31:0] known_ids[$];

    limit_order_book_matcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold counted here while it runs.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Result checking and a watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) book.check_result(m_tdata, m_tuser, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_count <= 0;
            else if (idle_count >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else idle_count <= idle_count + 1;
        end
    end

    // Idles at random cycle by cycle, then offers one order until it is taken.
    task automatic send_order(order_t o);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {o.timestamp, o.quantity, o.price, o.ident};
        s_tuser <= {o.side, o.opcode};
        do @(posedge aclk); while (!s_tready);
        book.note_order(o);
        orders_sent++;
        if (o.opcode == OP_LIMIT) known_ids = {known_ids, o.ident};
    endtask

    function automatic order_t make_order(logic [1:0] op, logic sd, logic [31:0] id,
                                          logic [7:0] px, logic [31:0] qty);
        order_t o;
        o.opcode = op;
        o.side = sd;
        o.ident = id;
        o.price = px;
        o.quantity = qty;
        o.timestamp = 48'({$urandom, $urandom});
        return o;
    endfunction

    // Mostly orders near one price band with small sizes, so the book crosses.
    task automatic send_random(int count);
        order_t o;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            o = make_order(OP_LIMIT, 1'($urandom_range(1)), $urandom,
                           8'(112 + $urandom_range(16)), $urandom_range(1, 60));
            if ($urandom_range(9) == 0) o.price = 8'($urandom);
            if ($urandom_range(19) == 0) o.quantity = $urandom;
            if (r >= 60 && r < 75) o.opcode = OP_MARKET;
            else if (r >= 75 && r < 95 && known_ids.size() > 0) begin
                o.opcode = OP_CANCEL;
                o.ident = known_ids[$urandom_range(known_ids.size() - 1)];
            end else if (r >= 95) o.opcode = $urandom_range(1) ? OP_SPARE : OP_CANCEL;
            send_order(o);
        end
    endtask

    task automatic drain_book();
        s_tvalid <= 0;
        while (book.expected_fills.size() > 0) @(posedge aclk);
    endtask

    initial begin
        book = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        hold_cycles = 0;
        idle_count = 0;
        orders_sent = 0;
        send_idle_pct = 25;
        recv_stall_pct = 56;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty book cases, extremes of price, size, id and cancel codes.
        send_order(make_order(OP_MARKET, 1'b0, 32'h0000_0001, 8'd0, 32'd10));
        send_order(make_order(OP_CANCEL, 1'b0, 32'h1234_5678, 8'd0, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b0, 32'h0000_0002, 8'd50, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b0, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF));
        send_order(make_order(OP_LIMIT, 1'b1, 32'h0000_0000, 8'd0, 32'd7));
        send_order(make_order(OP_LIMIT, 1'b1, 32'hAAAA_5555, 8'd0, 32'hFFFF_FFFF));
        send_order(make_order(OP_LIMIT, 1'b0, 32'h0000_0003, 8'd10, 32'd5));
        send_order(make_order(OP_LIMIT, 1'b0, 32'h0000_0004, 8'd10, 32'd6));
        send_order(make_order(OP_LIMIT, 1'b0, 32'h0000_0005, 8'd10, 32'd7));
        send_order(make_order(OP_CANCEL, 1'b0, 32'h0000_0004, 8'd0, 32'd0));
        send_order(make_order(OP_SPARE, 1'b1, 32'h0000_0003, 8'd0, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b1, 32'h5555_AAAA, 8'd200, 32'd3));
        send_order(make_order(OP_LIMIT, 1'b1, 32'h0000_0006, 8'd9, 32'd20));
        send_order(make_order(OP_MARKET, 1'b1, 32'h0000_0007, 8'd255, 32'hFFFF_FFFF));
        send_order(make_order(OP_MARKET, 1'b0, 32'h0000_0008, 8'd0, 32'hFFFF_FFFF));
        send_order(make_order(OP_CANCEL, 1'b0, 32'hFFFF_FFFF, 8'd0, 32'd0));
        send_order(make_order(OP_SPARE, 1'b0, 32'h0000_0009, 8'd0, 32'd0));

        // Sender idles less than the receiver stalls.
        send_random(25);

        // Roles swapped, with a long receiver hold while orders keep coming.
        send_idle_pct = 56;
        recv_stall_pct = 25;
        hold_cycles <= 400;
        send_random(25);

        // No idling; fill the pool completely, then sweep it in one order.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_order(make_order(OP_MARKET, 1'b1, $urandom, 8'd0, 32'hFFFF_FFFF));
        send_order(make_order(OP_MARKET, 1'b0, $urandom, 8'd0, 32'hFFFF_FFFF));
        for (int i = 0; i < SLOTS + 2; i++)
            send_order(make_order(OP_LIMIT, 1'b1, $urandom, 8'(200 + i),
                                  $urandom_range(1, 9)));
        send_order(make_order(OP_MARKET, 1'b0, $urandom, 8'd0, 32'hFFFF_FFFF));
        send_random(26);

        drain_book();
        repeat (300) @(posedge aclk);
        $display("Covered %0d orders giving %0d results, %0d of them trades.",
                 orders_sent, book.results_seen, book.trades_seen);
        $display("Outcomes: rested %0d filled %0d expired %0d cancelled %0d",
                 book.kinds_seen[K_RESTED], book.kinds_seen[K_FILLED],
                 book.kinds_seen[K_EXPIRED], book.kinds_seen[K_CANCELLED]);
        $display("          unknown id %0d pool full %0d.",
                 book.kinds_seen[K_NOT_FOUND], book.kinds_seen[K_FULL]);
        if (book.mismatches == 0 && book.expected_fills.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("Failures: %0d mismatches, %0d results never arrived",
                     book.mismatches, book.expected_fills.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
